@@ hdl/sipb_pkg.sv @@
// Shared types, constants, command codes and the microcode program of the ISP bridge.
package sipb_pkg;

    // Number of device codes reported by the device list command.
    localparam int DEVICE_COUNT = 42;
    localparam int TABLE_SIZE   = 42;
    localparam int DEV_LIST_LEN = (DEVICE_COUNT > TABLE_SIZE) ? TABLE_SIZE : DEVICE_COUNT;
    localparam int TIDX_W       = 6;
    localparam int UPC_W        = 6;
    localparam int OUT_DATA_W   = 48;

    typedef logic [UPC_W-1:0]  t_upc;
    typedef logic [TIDX_W-1:0] t_tidx;

    // Host command letters.
    localparam logic [7:0] CMD_SEL_DEV   = 8'h54;
    localparam logic [7:0] CMD_IDENT     = 8'h53;
    localparam logic [7:0] CMD_SW_VER    = 8'h56;
    localparam logic [7:0] CMD_HW_VER    = 8'h76;
    localparam logic [7:0] CMD_DEV_LIST  = 8'h74;
    localparam logic [7:0] CMD_PROG_TYPE = 8'h70;
    localparam logic [7:0] CMD_AUTO_INC  = 8'h61;
    localparam logic [7:0] CMD_LED_ON    = 8'h78;
    localparam logic [7:0] CMD_LED_OFF   = 8'h79;
    localparam logic [7:0] CMD_ENTER     = 8'h50;
    localparam logic [7:0] CMD_LEAVE     = 8'h4C;
    localparam logic [7:0] CMD_WR_HI     = 8'h43;
    localparam logic [7:0] CMD_WR_LO     = 8'h63;
    localparam logic [7:0] CMD_RD_PROG   = 8'h52;
    localparam logic [7:0] CMD_SET_ADDR  = 8'h41;
    localparam logic [7:0] CMD_WR_EE     = 8'h44;
    localparam logic [7:0] CMD_RD_EE     = 8'h64;
    localparam logic [7:0] CMD_ERASE     = 8'h65;
    localparam logic [7:0] CMD_LOCK      = 8'h6C;
    localparam logic [7:0] CMD_SIG       = 8'h73;
    localparam logic [7:0] CMD_PAGE      = 8'h6D;
    localparam logic [7:0] CMD_UNI3      = 8'h3A;
    localparam logic [7:0] CMD_UNI4      = 8'h2E;
    localparam logic [7:0] CMD_ADDR_ZERO = 8'h30;

    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_UNKNOWN = 8'h3F;
    localparam logic [7:0] PROG_ECHO  = 8'h53;

    // SPI instruction bytes.
    localparam logic [7:0] OP_PROG_EN   = 8'hAC;
    localparam logic [7:0] OP_WR_HI     = 8'h48;
    localparam logic [7:0] OP_WR_LO     = 8'h40;
    localparam logic [7:0] OP_RD_HI     = 8'h28;
    localparam logic [7:0] OP_RD_LO     = 8'h20;
    localparam logic [7:0] OP_WR_EE     = 8'hC0;
    localparam logic [7:0] OP_RD_EE     = 8'hA0;
    localparam logic [7:0] OP_PAGE      = 8'h4C;
    localparam logic [7:0] OP_ERASE_B1  = 8'h80;
    localparam logic [7:0] OP_ERASE_B2  = 8'h04;
    localparam logic [7:0] OP_SIG       = 8'h30;

    // Result kinds, pin and LED codes.
    localparam logic [1:0] KIND_HOST  = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_PINS  = 2'd2;
    localparam logic [1:0] PIN_FLOAT  = 2'd0;
    localparam logic [1:0] PIN_LOW    = 2'd2;
    localparam logic [1:0] LED_GREEN  = 2'd0;
    localparam logic [1:0] LED_ORANGE = 2'd1;
    localparam logic [1:0] LED_RED    = 2'd2;

    localparam logic [7:0] DEV_TABLE [TABLE_SIZE] = '{
        8'h10, 8'h11, 8'h12, 8'h13, 8'h20, 8'h28, 8'h30, 8'h34, 8'h38, 8'h3A, 8'h3B, 8'h41,
        8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h48, 8'h4C, 8'h55, 8'h56, 8'h58, 8'h5C, 8'h5E,
        8'h61, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6C, 8'h70, 8'h71, 8'h72, 8'h73,
        8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79
    };

    // Parser phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ARGS = 3'b010,
        PH_WAIT = 3'b100
    } t_phase;

    typedef enum logic [1:0] {EM_NONE, EM_HOST, EM_FRAME, EM_PINS} t_emit;
    typedef enum logic [1:0] {TX_CONST, TX_REPLY, TX_TABLE} t_txsrc;
    typedef enum logic [2:0] {
        FR_ADDR_ARG, FR_ADDR_ZERO, FR_PROG, FR_ERASE, FR_SIG, FR_ARG3, FR_ARG4
    } t_frm;
    typedef enum logic [1:0] {LO_KEEP, LO_GREEN, LO_ORANGE, LO_RED} t_ledop;
    typedef enum logic [1:0] {PO_KEEP, PO_FLOAT, PO_LOW} t_pinop;
    typedef enum logic [1:0] {AO_KEEP, AO_INC, AO_LOAD, AO_CLEAR} t_addrop;
    typedef enum logic [1:0] {FO_KEEP, FO_CLEAR, FO_SET1, FO_INC} t_fsop;
    typedef enum logic [2:0] {
        SQ_NEXT, SQ_END, SQ_JMP, SQ_JR53, SQ_JFS0, SQ_JFS2, SQ_JTBL
    } t_seq;

    typedef struct packed {
        t_emit      emit;
        t_txsrc     txsrc;
        t_frm       frm;
        logic [7:0] konst;
        t_ledop     led;
        t_pinop     pin;
        t_addrop    addr;
        logic       dev_load;
        t_fsop      fs;
        logic       tbl_inc;
        t_seq       seq;
        logic       last;
        t_upc       target;
    } t_uword;

    // Datapath status used by the sequencer's branch conditions.
    typedef struct packed {
        logic out_free;
        logic reply_53;
        logic fs_zero;
        logic fs_two;
        logic tbl_more;
    } t_dp_stat;

    // Parser state seen by the dispatcher.
    typedef struct packed {
        t_phase     phase;
        logic [7:0] pending;
        logic [2:0] count;
        logic       dev_none;
    } t_parse;

    // What the dispatcher asks for when an input transfer is taken.
    typedef struct packed {
        logic   go;
        t_upc   entry;
        logic   ph_load;
        t_phase ph_next;
        logic   pend_load;
        logic   cnt_clr;
        logic   arg_store;
        logic   fs_clr;
    } t_disp;

    // Microcode entry points.
    localparam t_upc UA_SEL     = 6'd0;
    localparam t_upc UA_ADDR    = 6'd1;
    localparam t_upc UA_ZERO    = 6'd2;
    localparam t_upc UA_CR      = 6'd3;
    localparam t_upc UA_UNK     = 6'd4;
    localparam t_upc UA_INCCR   = 6'd5;
    localparam t_upc UA_IDENT   = 6'd6;
    localparam t_upc UA_SWV     = 6'd13;
    localparam t_upc UA_HWV     = 6'd15;
    localparam t_upc UA_PTYPE   = 6'd17;
    localparam t_upc UA_AINC    = 6'd18;
    localparam t_upc UA_LIST    = 6'd19;
    localparam t_upc UA_LED_ON  = 6'd21;
    localparam t_upc UA_LED_OFF = 6'd22;
    localparam t_upc UA_ENTER   = 6'd23;
    localparam t_upc UA_LEAVE   = 6'd25;
    localparam t_upc UA_X_WRHI  = 6'd26;
    localparam t_upc UA_X_WRLO  = 6'd27;
    localparam t_upc UA_X_WREE  = 6'd28;
    localparam t_upc UA_X_RDP   = 6'd29;
    localparam t_upc UA_X_RDEE  = 6'd30;
    localparam t_upc UA_X_PAGE  = 6'd31;
    localparam t_upc UA_X_ERASE = 6'd32;
    localparam t_upc UA_X_SIG   = 6'd33;
    localparam t_upc UA_X_UNI3  = 6'd34;
    localparam t_upc UA_X_UNI4  = 6'd35;
    localparam t_upc UA_R_ENTER = 6'd36;
    localparam t_upc UA_R_RDP   = 6'd39;
    localparam t_upc UA_R_RDEE  = 6'd43;
    localparam t_upc UA_R_SIG   = 6'd44;
    localparam t_upc UA_R_UNI   = 6'd48;

    function automatic logic [2:0] args_needed(input logic [7:0] c);
        logic [2:0] n;
        case (c)
            CMD_SEL_DEV, CMD_WR_HI, CMD_WR_LO, CMD_WR_EE: n = 3'd1;
            CMD_SET_ADDR: n = 3'd2;
            CMD_UNI3:     n = 3'd3;
            CMD_UNI4:     n = 3'd4;
            default:      n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] dev_code(input t_tidx idx);
        logic [7:0] v;
        v = 8'h00;
        if (int'(idx) < TABLE_SIZE) begin
            v = DEV_TABLE[idx];
        end
        return v;
    endfunction

    // The microcode program: one control word per step.
    function automatic t_uword ucode(input t_upc a);
        t_uword w;
        w = '{emit: EM_NONE, txsrc: TX_CONST, frm: FR_ADDR_ARG, konst: 8'h00,
              led: LO_KEEP, pin: PO_KEEP, addr: AO_KEEP, dev_load: 1'b0,
              fs: FO_KEEP, tbl_inc: 1'b0, seq: SQ_END, last: 1'b1, target: UA_SEL};
        case (a)
            6'd0: begin
                w.dev_load = 1'b1; w.emit = EM_HOST; w.konst = CH_CR;
            end
            6'd1: begin
                w.addr = AO_LOAD; w.emit = EM_HOST; w.konst = CH_CR;
            end
            6'd2: begin
                w.addr = AO_CLEAR; w.emit = EM_HOST; w.konst = CH_CR;
            end
            6'd3: begin
                w.emit = EM_HOST; w.konst = CH_CR;
            end
            6'd4: begin
                w.emit = EM_HOST; w.konst = CH_UNKNOWN;
            end
            6'd5: begin
                w.addr = AO_INC; w.emit = EM_HOST; w.konst = CH_CR;
            end
            6'd6:  begin w.emit = EM_HOST; w.konst = 8'h41; w.seq = SQ_NEXT; w.last = 1'b0; end
            6'd7:  begin w.emit = EM_HOST; w.konst = 8'h56; w.seq = SQ_NEXT; w.last = 1'b0; end
            6'd8:  begin w.emit = EM_HOST; w.konst = 8'h52; w.seq = SQ_NEXT; w.last = 1'b0; end
            6'd9:  begin w.emit = EM_HOST; w.konst = 8'h20; w.seq = SQ_NEXT; w.last = 1'b0; end
            6'd10: begin w.emit = EM_HOST; w.konst = 8'h49; w.seq = SQ_NEXT; w.last = 1'b0; end
            6'd11: begin w.emit = EM_HOST; w.konst = 8'h53; w.seq = SQ_NEXT; w.last = 1'b0; end
            6'd12: begin w.emit = EM_HOST; w.konst = 8'h50; end
            6'd13: begin w.emit = EM_HOST; w.konst = 8'h33; w.seq = SQ_NEXT; w.last = 1'b0; end
            6'd14: begin w.emit = EM_HOST; w.konst = 8'h33; end
            6'd15: begin w.emit = EM_HOST; w.konst = 8'h31; w.seq = SQ_NEXT; w.last = 1'b0; end
            6'd16: begin w.emit = EM_HOST; w.konst = 8'h30; end
            6'd17: begin w.emit = EM_HOST; w.konst = 8'h53; end
            6'd18: begin w.emit = EM_HOST; w.konst = 8'h59; end
            6'd19: begin
                w.emit = EM_HOST; w.txsrc = TX_TABLE; w.tbl_inc = 1'b1;
                w.seq = SQ_JTBL; w.target = UA_LIST; w.last = 1'b0;
            end
            6'd20: begin w.emit = EM_HOST; w.konst = 8'h00; end
            6'd21: begin
                w.led = LO_ORANGE; w.emit = EM_PINS; w.seq = SQ_JMP;
                w.target = UA_CR; w.last = 1'b0;
            end
            6'd22: begin
                w.led = LO_GREEN; w.emit = EM_PINS; w.seq = SQ_JMP;
                w.target = UA_CR; w.last = 1'b0;
            end
            6'd23: begin
                w.pin = PO_LOW; w.emit = EM_PINS; w.seq = SQ_NEXT; w.last = 1'b0;
            end
            6'd24: begin w.emit = EM_FRAME; w.frm = FR_PROG; end
            6'd25: begin
                w.pin = PO_FLOAT; w.led = LO_GREEN; w.emit = EM_PINS;
                w.seq = SQ_JMP; w.target = UA_CR; w.last = 1'b0;
            end
            6'd26: begin w.emit = EM_FRAME; w.frm = FR_ADDR_ARG;  w.konst = OP_WR_HI; end
            6'd27: begin w.emit = EM_FRAME; w.frm = FR_ADDR_ARG;  w.konst = OP_WR_LO; end
            6'd28: begin w.emit = EM_FRAME; w.frm = FR_ADDR_ARG;  w.konst = OP_WR_EE; end
            6'd29: begin w.emit = EM_FRAME; w.frm = FR_ADDR_ZERO; w.konst = OP_RD_HI; end
            6'd30: begin w.emit = EM_FRAME; w.frm = FR_ADDR_ZERO; w.konst = OP_RD_EE; end
            6'd31: begin w.emit = EM_FRAME; w.frm = FR_ADDR_ZERO; w.konst = OP_PAGE; end
            6'd32: begin w.emit = EM_FRAME; w.frm = FR_ERASE; end
            6'd33: begin w.emit = EM_FRAME; w.frm = FR_SIG; end
            6'd34: begin w.emit = EM_FRAME; w.frm = FR_ARG3; end
            6'd35: begin w.emit = EM_FRAME; w.frm = FR_ARG4; end
            6'd36: begin w.seq = SQ_JR53; w.target = 6'd38; w.last = 1'b0; end
            6'd37: begin
                w.led = LO_RED; w.emit = EM_PINS; w.seq = SQ_JMP;
                w.target = UA_UNK; w.last = 1'b0;
            end
            6'd38: begin
                w.led = LO_ORANGE; w.emit = EM_PINS; w.seq = SQ_JMP;
                w.target = UA_CR; w.last = 1'b0;
            end
            6'd39: begin w.seq = SQ_JFS0; w.target = 6'd41; w.last = 1'b0; end
            6'd40: begin
                w.fs = FO_CLEAR; w.addr = AO_INC; w.emit = EM_HOST; w.txsrc = TX_REPLY;
            end
            6'd41: begin
                w.fs = FO_SET1; w.emit = EM_HOST; w.txsrc = TX_REPLY;
                w.seq = SQ_NEXT; w.last = 1'b0;
            end
            6'd42: begin w.emit = EM_FRAME; w.frm = FR_ADDR_ZERO; w.konst = OP_RD_LO; end
            6'd43: begin w.addr = AO_INC; w.emit = EM_HOST; w.txsrc = TX_REPLY; end
            6'd44: begin w.seq = SQ_JFS2; w.target = 6'd47; w.last = 1'b0; end
            6'd45: begin
                w.fs = FO_INC; w.emit = EM_HOST; w.txsrc = TX_REPLY;
                w.seq = SQ_NEXT; w.last = 1'b0;
            end
            6'd46: begin w.emit = EM_FRAME; w.frm = FR_SIG; end
            6'd47: begin w.fs = FO_CLEAR; w.emit = EM_HOST; w.txsrc = TX_REPLY; end
            6'd48: begin
                w.emit = EM_HOST; w.txsrc = TX_REPLY; w.seq = SQ_JMP;
                w.target = UA_CR; w.last = 1'b0;
            end
            default: begin
                w.last = 1'b0;
            end
        endcase
        return w;
    endfunction

endpackage

@@ hdl/sipb_dispatch.sv @@
// Command decoder: maps an input transfer and the parser state to a microcode entry.
module sipb_dispatch (
    input  logic                  i_cmd,
    input  logic [7:0]            i_host_byte,
    input  sipb_pkg::t_parse      i_parse,
    output sipb_pkg::t_disp       o_disp
);
    import sipb_pkg::*;

    logic       exec_ok;
    t_upc       exec_entry;
    logic       reply_ok;
    t_upc       reply_entry;
    logic [7:0] exec_cmd;
    logic [2:0] cnt_inc;

    assign cnt_inc  = i_parse.count + 3'd1;
    assign exec_cmd = (i_parse.phase == PH_ARGS) ? i_parse.pending : i_host_byte;

    // Entry of a command once its argument bytes are all present.
    always_comb begin
        exec_ok    = 1'b1;
        exec_entry = UA_CR;
        case (exec_cmd)
            CMD_SEL_DEV:   exec_entry = UA_SEL;
            CMD_ENTER:     exec_entry = UA_ENTER;
            CMD_LEAVE:     exec_entry = UA_LEAVE;
            CMD_WR_HI:     exec_entry = UA_X_WRHI;
            CMD_WR_LO:     exec_entry = UA_X_WRLO;
            CMD_RD_PROG:   exec_entry = UA_X_RDP;
            CMD_SET_ADDR:  exec_entry = UA_ADDR;
            CMD_WR_EE:     exec_entry = UA_X_WREE;
            CMD_RD_EE:     exec_entry = UA_X_RDEE;
            CMD_ERASE:     exec_entry = UA_X_ERASE;
            CMD_LOCK:      exec_entry = UA_CR;
            CMD_SIG:       exec_entry = UA_X_SIG;
            CMD_PAGE:      exec_entry = UA_X_PAGE;
            CMD_UNI3:      exec_entry = UA_X_UNI3;
            CMD_UNI4:      exec_entry = UA_X_UNI4;
            CMD_ADDR_ZERO: exec_entry = UA_ZERO;
            default:       exec_ok = 1'b0;
        endcase
    end

    // Entry of the follow-up once a frame reply comes back.
    always_comb begin
        reply_ok    = 1'b1;
        reply_entry = UA_CR;
        case (i_parse.pending)
            CMD_ENTER:                     reply_entry = UA_R_ENTER;
            CMD_WR_HI, CMD_WR_EE:          reply_entry = UA_INCCR;
            CMD_WR_LO, CMD_ERASE, CMD_PAGE: reply_entry = UA_CR;
            CMD_RD_PROG:                   reply_entry = UA_R_RDP;
            CMD_RD_EE:                     reply_entry = UA_R_RDEE;
            CMD_SIG:                       reply_entry = UA_R_SIG;
            CMD_UNI3, CMD_UNI4:            reply_entry = UA_R_UNI;
            default:                       reply_ok = 1'b0;
        endcase
    end

    always_comb begin
        o_disp = '{go: 1'b0, entry: UA_CR, ph_load: 1'b0, ph_next: PH_IDLE,
                   pend_load: 1'b0, cnt_clr: 1'b0, arg_store: 1'b0, fs_clr: 1'b0};
        if (i_cmd) begin
            if (i_parse.phase == PH_WAIT) begin
                o_disp.ph_load = 1'b1;
                o_disp.go      = reply_ok;
                o_disp.entry   = reply_entry;
            end
        end else if (i_parse.phase == PH_IDLE) begin
            case (i_host_byte)
                CMD_IDENT:     begin o_disp.go = 1'b1; o_disp.entry = UA_IDENT;   end
                CMD_SW_VER:    begin o_disp.go = 1'b1; o_disp.entry = UA_SWV;     end
                CMD_HW_VER:    begin o_disp.go = 1'b1; o_disp.entry = UA_HWV;     end
                CMD_DEV_LIST:  begin o_disp.go = 1'b1; o_disp.entry = UA_LIST;    end
                CMD_PROG_TYPE: begin o_disp.go = 1'b1; o_disp.entry = UA_PTYPE;   end
                CMD_AUTO_INC:  begin o_disp.go = 1'b1; o_disp.entry = UA_AINC;    end
                CMD_LED_ON:    begin o_disp.go = 1'b1; o_disp.entry = UA_LED_ON;  end
                CMD_LED_OFF:   begin o_disp.go = 1'b1; o_disp.entry = UA_LED_OFF; end
                default: begin
                    if (i_parse.dev_none && (i_host_byte != CMD_SEL_DEV)) begin
                        o_disp.go    = 1'b1;
                        o_disp.entry = UA_UNK;
                    end else begin
                        o_disp.pend_load = 1'b1;
                        o_disp.cnt_clr   = 1'b1;
                        if (args_needed(i_host_byte) == 3'd0) begin
                            o_disp.fs_clr = 1'b1;
                            o_disp.go     = exec_ok;
                            o_disp.entry  = exec_entry;
                        end else begin
                            o_disp.ph_load = 1'b1;
                            o_disp.ph_next = PH_ARGS;
                        end
                    end
                end
            endcase
        end else if (i_parse.phase == PH_ARGS) begin
            o_disp.arg_store = 1'b1;
            if (cnt_inc >= args_needed(i_parse.pending)) begin
                o_disp.ph_load = 1'b1;
                o_disp.fs_clr  = 1'b1;
                o_disp.go      = exec_ok;
                o_disp.entry   = exec_entry;
            end
        end
    end

endmodule

@@ hdl/sipb_sequencer.sv @@
// Microcode sequencer: step counter, program lookup and conditional jumps.
module sipb_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  sipb_pkg::t_upc       i_entry,
    input  sipb_pkg::t_dp_stat   i_stat,
    output logic                 o_busy,
    output logic                 o_fire,
    output sipb_pkg::t_uword     o_uword
);
    import sipb_pkg::*;

    logic   r_busy, n_busy;
    t_upc   r_upc, n_upc;
    t_uword uw;
    logic   fire;
    logic   take;

    always_comb begin
        uw   = ucode(r_upc);
        fire = r_busy && ((uw.emit == EM_NONE) || i_stat.out_free);
        case (uw.seq)
            SQ_JMP:  take = 1'b1;
            SQ_JR53: take = i_stat.reply_53;
            SQ_JFS0: take = i_stat.fs_zero;
            SQ_JFS2: take = i_stat.fs_two;
            SQ_JTBL: take = i_stat.tbl_more;
            default: take = 1'b0;
        endcase
        n_busy = r_busy;
        n_upc  = r_upc;
        if (i_go) begin
            n_busy = 1'b1;
            n_upc  = i_entry;
        end else if (fire) begin
            if (uw.seq == SQ_END) begin
                n_busy = 1'b0;
            end else if (take) begin
                n_upc = uw.target;
            end else begin
                n_upc = r_upc + t_upc'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= '0;
        end else begin
            r_busy <= n_busy;
            r_upc  <= n_upc;
        end
    end

    assign o_busy  = r_busy;
    assign o_fire  = fire;
    assign o_uword = uw;

endmodule

@@ hdl/sipb_datapath.sv @@
// Datapath: parser and target state registers, result formatting and the output register.
module sipb_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [7:0]                  i_host_byte,
    input  logic [7:0]                  i_reply_byte,
    input  sipb_pkg::t_disp             i_disp,
    input  logic                        i_fire,
    input  sipb_pkg::t_uword            i_uword,
    input  logic                        i_out_ready,
    output sipb_pkg::t_dp_stat          o_stat,
    output sipb_pkg::t_parse            o_parse,
    output logic                        o_out_valid,
    output logic [1:0]                  o_out_kind,
    output logic [sipb_pkg::OUT_DATA_W-1:0] o_out_data,
    output logic                        o_out_last
);
    import sipb_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_pending, n_pending;
    logic [2:0] r_count, n_count;
    logic [7:0] r_args [4];
    logic [7:0] r_dev, n_dev;
    logic [15:0] r_addr, n_addr;
    logic [1:0] r_fstep, n_fstep;
    logic [1:0] r_led, n_led;
    logic [1:0] r_pin, n_pin;
    t_tidx      r_tidx, n_tidx;
    logic [7:0] r_reply;

    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_okind;
    logic [OUT_DATA_W-1:0] r_odata;
    logic        r_olast;

    logic        load;
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [31:0] frm;
    logic        slot;

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_count   = r_count;
        n_dev     = r_dev;
        n_addr    = r_addr;
        n_fstep   = r_fstep;
        n_led     = r_led;
        n_pin     = r_pin;
        n_tidx    = r_tidx;

        if (i_accept) begin
            if (i_disp.ph_load) n_phase = i_disp.ph_next;
            if (i_disp.pend_load) n_pending = i_host_byte;
            if (i_disp.cnt_clr) n_count = 3'd0;
            if (i_disp.arg_store) n_count = r_count + 3'd1;
            if (i_disp.fs_clr) n_fstep = 2'd0;
            if (i_disp.go) n_tidx = '0;
        end

        if (i_fire) begin
            if (i_uword.emit == EM_FRAME) n_phase = PH_WAIT;
            if (i_uword.dev_load) n_dev = r_args[0];
            if (i_uword.tbl_inc) n_tidx = r_tidx + t_tidx'(1);
            case (i_uword.led)
                LO_GREEN:  n_led = LED_GREEN;
                LO_ORANGE: n_led = LED_ORANGE;
                LO_RED:    n_led = LED_RED;
                default:   n_led = r_led;
            endcase
            case (i_uword.pin)
                PO_FLOAT: n_pin = PIN_FLOAT;
                PO_LOW:   n_pin = PIN_LOW;
                default:  n_pin = r_pin;
            endcase
            case (i_uword.addr)
                AO_INC:   n_addr = r_addr + 16'd1;
                AO_LOAD:  n_addr = {r_args[0], r_args[1]};
                AO_CLEAR: n_addr = 16'd0;
                default:  n_addr = r_addr;
            endcase
            case (i_uword.fs)
                FO_CLEAR: n_fstep = 2'd0;
                FO_SET1:  n_fstep = 2'd1;
                FO_INC:   n_fstep = r_fstep + 2'd1;
                default:  n_fstep = r_fstep;
            endcase
        end
    end

    // Result formatting; pin and LED fields show the values this step leaves.
    always_comb begin
        case (i_uword.txsrc)
            TX_REPLY: tx = r_reply;
            TX_TABLE: tx = dev_code(r_tidx);
            default:  tx = i_uword.konst;
        endcase
        slot = 1'b0;
        case (i_uword.frm)
            FR_ADDR_ARG:  frm = {r_args[0], r_addr[7:0], r_addr[15:8], i_uword.konst};
            FR_ADDR_ZERO: frm = {8'h00, r_addr[7:0], r_addr[15:8], i_uword.konst};
            FR_PROG: begin
                frm  = {8'h00, 8'h00, PROG_ECHO, OP_PROG_EN};
                slot = 1'b1;
            end
            FR_ERASE: frm = {8'h00, OP_ERASE_B2, OP_ERASE_B1, OP_PROG_EN};
            FR_SIG:   frm = {8'h00, 8'd2 - {6'd0, r_fstep}, 8'h00, OP_SIG};
            FR_ARG3:  frm = {8'h00, r_args[2], r_args[1], r_args[0]};
            FR_ARG4:  frm = {r_args[3], r_args[2], r_args[1], r_args[0]};
            default:  frm = 32'd0;
        endcase
        case (i_uword.emit)
            EM_FRAME: kind = KIND_FRAME;
            EM_PINS:  kind = KIND_PINS;
            default:  kind = KIND_HOST;
        endcase
    end

    assign load = i_fire && (i_uword.emit != EM_NONE);

    always_comb begin
        n_ovalid = r_ovalid;
        if (load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pending <= 8'd0;
            r_count   <= 3'd0;
            r_dev     <= 8'd0;
            r_addr    <= 16'd0;
            r_fstep   <= 2'd0;
            r_led     <= LED_GREEN;
            r_pin     <= PIN_FLOAT;
            r_tidx    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_count   <= n_count;
            r_dev     <= n_dev;
            r_addr    <= n_addr;
            r_fstep   <= n_fstep;
            r_led     <= n_led;
            r_pin     <= n_pin;
            r_tidx    <= n_tidx;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_reply <= i_reply_byte;
            if (i_disp.arg_store) begin
                r_args[r_count[1:0]] <= i_host_byte;
            end
        end
        if (load) begin
            r_okind <= kind;
            r_olast <= i_uword.last;
            r_odata <= {3'b000, n_led, n_pin, slot,
                        (kind == KIND_FRAME) ? frm : 32'd0,
                        (kind == KIND_HOST) ? tx : 8'd0};
        end
    end

    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_stat.reply_53 = (r_reply == PROG_ECHO);
    assign o_stat.fs_zero  = (r_fstep == 2'd0);
    assign o_stat.fs_two   = (r_fstep == 2'd2);
    assign o_stat.tbl_more = (r_tidx != t_tidx'(DEV_LIST_LEN - 1));

    assign o_parse.phase    = r_phase;
    assign o_parse.pending  = r_pending;
    assign o_parse.count    = r_count;
    assign o_parse.dev_none = (r_dev == 8'd0);

    assign o_out_valid = r_ovalid;
    assign o_out_kind  = r_okind;
    assign o_out_data  = r_odata;
    assign o_out_last  = r_olast;

endmodule

@@ hdl/serial_isp_programmer_bridge.sv @@
// Top level of the serial in-system programmer bridge: ports and module wiring.
// The first result of an input transfer is loaded into the output register by the routine's first
// step, or by a later one when the routine opens with a branch step (program-mode, program read
// and signature replies). A new input is taken only once the previous one's routine has finished;
// a routine has 0 to 3 microcode steps for most commands, 7 for the identifier, 43 for the device list.
// Reset is synchronous and active low: parser idle, no device, address 0, LED green, pin floating.
module serial_isp_programmer_bridge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream. One transfer is a host byte or a target reply byte.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] host_byte, [15:8] reply_byte
    input  logic [0:0]  s_axis_tuser,   // [0] cmd
    // Result stream. One transfer is a host byte, an SPI frame or a pin and LED update.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] tx_byte, [15:8] spi_byte0, [23:16] spi_byte1,
                                        // [31:24] spi_byte2, [39:32] spi_byte3, [40] reply_slot,
                                        // [42:41] reset_pin, [44:43] led_colour, [47:45] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
    output logic        m_axis_tlast    // last result caused by one input transfer
);
    import sipb_pkg::*;

    logic     accept;
    logic     busy;
    logic     fire;
    t_uword   uword;
    t_disp    disp;
    t_parse   parse;
    t_dp_stat stat;

    // The block takes a new input whenever the sequencer has finished the previous one's
    // program; a result still waiting in the output register does not hold the input side.
    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // The dispatcher looks at the incoming byte and the parser state and picks the
    // microcode routine, and the bookkeeping of argument bytes, for this transfer.
    sipb_dispatch u_dispatch (
        .i_cmd       (s_axis_tuser[0]),
        .i_host_byte (s_axis_tdata[7:0]),
        .i_parse     (parse),
        .o_disp      (disp)
    );

    // The sequencer steps through the routine one control word per cycle, holding on a
    // step that emits while the output register is still occupied.
    sipb_sequencer u_sequencer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (accept && disp.go),
        .i_entry (disp.entry),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_fire  (fire),
        .o_uword (uword)
    );

    // The datapath keeps device, address, frame step, LED and reset pin state, and
    // builds each result transfer into the output register.
    sipb_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_host_byte  (s_axis_tdata[7:0]),
        .i_reply_byte (s_axis_tdata[15:8]),
        .i_disp       (disp),
        .i_fire       (fire),
        .i_uword      (uword),
        .i_out_ready  (m_axis_tready),
        .o_stat       (stat),
        .o_parse      (parse),
        .o_out_valid  (m_axis_tvalid),
        .o_out_kind   (m_axis_tuser),
        .o_out_data   (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

endmodule
